[hw/rtl/icpr_pkg.sv]
// Shared types and constants for the I2C command packet receiver.
// No dependencies; every other file of the block uses this package.
package icpr_pkg;

    // Bytes in one command packet: feature, command, checksum
    localparam int PACKET_BYTES = 3;

    typedef enum logic [1:0] {
        EV_STOP   = 2'd0,
        EV_ADDR_W = 2'd1,
        EV_ADDR_R = 2'd2,
        EV_DATA   = 2'd3
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } rx_state_t;

    typedef enum logic [1:0] {
        E_NONE        = 2'd0,
        E_PROTO       = 2'd1,
        E_MALFORMED   = 2'd2,
        E_UNSUPPORTED = 2'd3
    } err_t;

    // One bus event as held in the input register
    typedef struct packed {
        ev_t        op;
        logic [7:0] rx_byte;
        logic       byte_full;
    } icpr_event_t;

    // One status result as handed to the output register
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       release_clock;
        rx_state_t  rx_state;
        err_t       error;
    } icpr_result_t;

endpackage

[hw/rtl/icpr_in_reg.sv]
// Input register stage of the I2C command packet receiver.
// Depends on icpr_pkg for the event struct.
module icpr_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  icpr_pkg::icpr_event_t in_event,
    output logic                 ev_valid,
    input  logic                 ev_ready,
    output icpr_pkg::icpr_event_t ev_data
);

    logic                  valid_reg;
    logic                  valid_next;
    icpr_pkg::icpr_event_t data_reg;

    // Take a new request whenever the held one is empty or moving on
    assign in_ready = !valid_reg || ev_ready;

    always_comb
    begin
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev_data  = data_reg;

endmodule

[hw/rtl/icpr_core.sv]
// Receive state machine, byte count and checksum sum of the packet receiver.
// Depends on icpr_pkg for event, state, error and result types.
module icpr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  icpr_pkg::icpr_event_t ev,
    output icpr_pkg::icpr_result_t result
);

    localparam logic [1:0] LAST_INDEX = 2'(icpr_pkg::PACKET_BYTES - 1);

    icpr_pkg::rx_state_t state_reg, state_next;
    icpr_pkg::err_t      error_reg, error_next;
    logic [1:0]          count_reg, count_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          expect_sum;
    logic                tx_valid;
    logic                release_clock;

    // Checksum is the two's complement of feature plus command
    assign expect_sum = 8'd0 - sum_reg;

    // Next state, error, count and sum
    always_comb
    begin
        state_next = state_reg;
        error_next = error_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        priority if (ev.op == icpr_pkg::EV_STOP)
        begin
            state_next = icpr_pkg::ST_IDLE;
            error_next = icpr_pkg::E_NONE;
        end
        else if (state_reg == icpr_pkg::ST_ERR)
        begin
            state_next = state_reg;
        end
        else
        begin
            unique case (ev.op)
                icpr_pkg::EV_ADDR_W:
                begin
                    state_next = icpr_pkg::ST_RECV;
                    count_next = 2'd0;
                    sum_next   = 8'd0;
                end
                icpr_pkg::EV_ADDR_R:
                begin
                    if (state_reg != icpr_pkg::ST_DONE)
                    begin
                        state_next = icpr_pkg::ST_ERR;
                        error_next = icpr_pkg::E_PROTO;
                    end
                end
                default:
                begin
                    if (state_reg == icpr_pkg::ST_RECV && ev.byte_full)
                    begin
                        if (count_reg >= LAST_INDEX)
                        begin
                            error_next = (expect_sum == ev.rx_byte) ?
                                         icpr_pkg::E_UNSUPPORTED : icpr_pkg::E_MALFORMED;
                            state_next = icpr_pkg::ST_DONE;
                            count_next = 2'd0;
                            sum_next   = 8'd0;
                        end
                        else
                        begin
                            sum_next   = sum_reg + ev.rx_byte;
                            count_next = count_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_next = icpr_pkg::ST_ERR;
                        error_next = icpr_pkg::E_PROTO;
                    end
                end
            endcase
        end
    end

    // Transmit and clock-release outputs
    always_comb
    begin
        tx_valid      = 1'b0;
        release_clock = 1'b1;
        priority if (ev.op == icpr_pkg::EV_STOP || state_reg == icpr_pkg::ST_ERR)
        begin
            release_clock = 1'b1;
        end
        else
        begin
            unique case (ev.op)
                icpr_pkg::EV_ADDR_W:
                begin
                    // Address ack is done by hardware; keep stretching
                    release_clock = 1'b0;
                end
                icpr_pkg::EV_ADDR_R:
                begin
                    tx_valid = (state_reg == icpr_pkg::ST_DONE);
                end
                default:
                begin
                    release_clock = !(state_reg == icpr_pkg::ST_RECV && ev.byte_full &&
                                      count_reg < LAST_INDEX);
                end
            endcase
        end
    end

    assign result.tx_valid      = tx_valid;
    assign result.tx_byte       = tx_valid ? {6'd0, error_reg} : 8'd0;
    assign result.release_clock = release_clock;
    assign result.rx_state      = state_next;
    assign result.error         = error_next;

    // Advance the state only when a request moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icpr_pkg::ST_IDLE;
            error_reg <= icpr_pkg::E_NONE;
            count_reg <= 2'd0;
            sum_reg   <= 8'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            error_reg <= error_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[hw/rtl/icpr_out_reg.sv]
// Result register of the packet receiver, holds a result until taken.
// Depends on icpr_pkg for the result struct.
module icpr_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    output logic                   load_ready,
    input  icpr_pkg::icpr_result_t result,
    output logic                   out_valid,
    input  logic                   out_ready,
    output icpr_pkg::icpr_result_t held
);

    logic                   valid_reg;
    logic                   valid_next;
    icpr_pkg::icpr_result_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (load_ready)
        begin
            valid_next = load;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

[hw/rtl/i2c_command_packet_receiver.sv]
// Path: a request accepted into the input register is decoded and loaded into the result register,
// which raises out_valid.
// Throughput: one bus event per cycle while out_ready does not stall the result register.
// Reset (rst_n low, asynchronous): state idle, no error, count and sum zero, no
// request held in either register.
module i2c_command_packet_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic       byte_full,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       release_clock,
    output logic [1:0] rx_state_out,
    output logic [1:0] error_out
);

    icpr_pkg::icpr_event_t  in_event;
    icpr_pkg::icpr_event_t  ev_data;
    icpr_pkg::icpr_result_t result;
    icpr_pkg::icpr_result_t held;
    logic                   ev_valid;
    logic                   ev_ready;

    assign in_event.op        = icpr_pkg::ev_t'(op);
    assign in_event.rx_byte   = rx_byte;
    assign in_event.byte_full = byte_full;

    icpr_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_event (in_event),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev_data  (ev_data)
    );

    icpr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (ev_valid && ev_ready),
        .ev     (ev_data),
        .result (result)
    );

    icpr_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ev_valid),
        .load_ready (ev_ready),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .held       (held)
    );

    assign tx_valid      = held.tx_valid;
    assign tx_byte       = held.tx_byte;
    assign release_clock = held.release_clock;
    assign rx_state_out  = held.rx_state;
    assign error_out     = held.error;

endmodule

[hw/rtl/icpr_checker.sv]
// Port-level checks for the I2C command packet receiver, bound to the top level.
// Depends on icpr_pkg for state and error codes.
module icpr_assertions (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       release_clock,
    input logic [1:0] rx_state_out,
    input logic [1:0] error_out
);

    // A status byte goes out only from processed, carrying the packet error
    a_tx_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |->
            rx_state_out == icpr_pkg::ST_DONE && tx_byte == {6'd0, error_out} &&
            (error_out == icpr_pkg::E_MALFORMED || error_out == icpr_pkg::E_UNSUPPORTED))
        else $error("status byte sent outside processed state or with wrong code");

    // No status byte means a zero byte
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("nonzero status byte without transmit");

    // Error state always carries a protocol error
    a_err_proto: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_state_out == icpr_pkg::ST_ERR |-> error_out == icpr_pkg::E_PROTO)
        else $error("error state without protocol error");

    // Idle is only reached by stop: error cleared and clock released
    a_idle_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_state_out == icpr_pkg::ST_IDLE |->
            error_out == icpr_pkg::E_NONE && release_clock && !tx_valid)
        else $error("idle result without stop behavior");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(error_out) &&
            $stable(rx_state_out))
        else $error("stalled result changed");

endmodule

bind i2c_command_packet_receiver icpr_assertions u_icpr_checker (.*);

[test/icpr_checker.sv]
// Checker for the I2C command packet receiver: watches both request channels,
// predicts each status result and compares it with what the block returns.
// Depends on icpr_pkg for the event, state, error and result types.
`timescale 1ns / 100ps

module icpr_checker
    import icpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic       byte_full,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       tx_valid,
    input  logic [7:0] tx_byte,
    input  logic       release_clock,
    input  logic [1:0] rx_state_out,
    input  logic [1:0] error_out,
    output int         fail_count,
    output int         pending
);

    // Predicted receiver state
    rx_state_t    bus_state;
    err_t         err_code;
    logic [1:0]   byte_cnt;
    logic [7:0]   sum_acc;

    icpr_result_t status_q[$];

    // Advance the predicted state by one bus event and return its status
    function automatic icpr_result_t next_status(ev_t ev, logic [7:0] data, logic full);
        icpr_result_t res;
        logic [7:0]   want;
        res = '0;
        if (ev == EV_STOP)
        begin
            bus_state = ST_IDLE;
            err_code  = E_NONE;
            res.release_clock = 1'b1;
        end
        else if (bus_state == ST_ERR)
        begin
            res.release_clock = 1'b1;
        end
        else if (ev == EV_ADDR_W)
        begin
            // Hardware acks the address, so the clock stays stretched
            bus_state = ST_RECV;
            byte_cnt  = '0;
            sum_acc   = '0;
        end
        else if (ev == EV_ADDR_R)
        begin
            if (bus_state == ST_DONE)
            begin
                res.tx_valid = 1'b1;
                res.tx_byte  = {6'd0, err_code};
            end
            else
            begin
                bus_state = ST_ERR;
                err_code  = E_PROTO;
            end
            res.release_clock = 1'b1;
        end
        else if (bus_state == ST_RECV && full)
        begin
            if (int'(byte_cnt) >= PACKET_BYTES - 1)
            begin
                // Checksum byte: must cancel feature plus command
                want      = 8'd0 - sum_acc;
                err_code  = (want == data) ? E_UNSUPPORTED : E_MALFORMED;
                bus_state = ST_DONE;
                byte_cnt  = '0;
                sum_acc   = '0;
                res.release_clock = 1'b1;
            end
            else
            begin
                sum_acc  = sum_acc + data;
                byte_cnt = byte_cnt + 2'd1;
            end
        end
        else
        begin
            bus_state = ST_ERR;
            err_code  = E_PROTO;
            res.release_clock = 1'b1;
        end
        res.rx_state = bus_state;
        res.error    = err_code;
        return res;
    endfunction

    // Compare returned results first, then queue the prediction for a new request
    always @(posedge clk or negedge rst_n)
    begin
        icpr_result_t want;
        if (!rst_n)
        begin
            bus_state  = ST_IDLE;
            err_code   = E_NONE;
            byte_cnt   = '0;
            sum_acc    = '0;
            status_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("status result with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (tx_valid !== want.tx_valid)
                    begin
                        $error("tx_valid: expected %0h, got %0h", want.tx_valid, tx_valid);
                        fail_count++;
                    end
                    if (tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %0h, got %0h", want.tx_byte, tx_byte);
                        fail_count++;
                    end
                    if (release_clock !== want.release_clock)
                    begin
                        $error("release_clock: expected %0h, got %0h",
                               want.release_clock, release_clock);
                        fail_count++;
                    end
                    if (rx_state_out !== want.rx_state)
                    begin
                        $error("rx_state_out: expected %0h, got %0h",
                               want.rx_state, rx_state_out);
                        fail_count++;
                    end
                    if (error_out !== want.error)
                    begin
                        $error("error_out: expected %0h, got %0h", want.error, error_out);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                status_q.push_back(next_status(ev_t'(op), rx_byte, byte_full));
            pending = status_q.size();
        end
    end

endmodule

[test/tb_top.sv]
// Top of the I2C command packet receiver testbench: clock, reset, bus event
// stimulus, receiver stalls, watchdog and verdict. Depends on icpr_pkg,
// icpr_checker and the i2c_command_packet_receiver block.
`timescale 1ns / 100ps

module tb_top;
    import icpr_pkg::*;

    localparam int RANDOM_EVENTS = 1400;
    localparam int IDLE_LIMIT    = 1000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] op        = EV_STOP;
    logic [7:0] rx_byte   = 8'd0;
    logic       byte_full = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       release_clock;
    logic [1:0] rx_state_out;
    logic [1:0] error_out;

    int fail_count;
    int pending;
    int sent_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    logic [7:0] stall_mask = 8'hFF;
    int         stall_tick = 0;

    i2c_command_packet_receiver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .rx_byte       (rx_byte),
        .byte_full     (byte_full),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .release_clock (release_clock),
        .rx_state_out  (rx_state_out),
        .error_out     (error_out)
    );

    icpr_checker status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .rx_byte       (rx_byte),
        .byte_full     (byte_full),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .release_clock (release_clock),
        .rx_state_out  (rx_state_out),
        .error_out     (error_out),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the receiver on a rotating mask, reloaded every so often
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 96 == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_mask = 8'hFF;
            else
                stall_mask = 8'($urandom) | 8'h01;
        end
        out_ready <= rst_n && stall_mask[stall_tick % 8];
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Hold one request until accepted, then go on or drop valid for a gap
    task automatic send_event(input ev_t ev, input logic [7:0] data, input logic full);
        in_valid  <= 1'b1;
        op        <= ev;
        rx_byte   <= data;
        byte_full <= full;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(50, 150);
            else
                burst_left = $urandom_range(0, 12);
        end
    endtask

    // Non-data event with a random byte on the bus so the data bits keep toggling
    task automatic send_ctrl(input ev_t ev);
        send_event(ev, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_data(input logic [7:0] data);
        send_event(EV_DATA, data, 1'b1);
    endtask

    // Address write followed by feature, command and a good or bad checksum
    task automatic send_packet(input logic [7:0] feature, input logic [7:0] command,
                               input logic good);
        logic [7:0] chk;
        chk = 8'd0 - (feature + command);
        if (!good)
            chk = chk + 8'($urandom_range(1, 255));
        send_ctrl(EV_ADDR_W);
        send_data(feature);
        send_data(command);
        send_data(chk);
    endtask

    initial
    begin
        int roll;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: protocol errors, error hold, both checksum outcomes, reads
        send_ctrl(EV_STOP);
        send_ctrl(EV_ADDR_R);                 // read while idle
        send_data(8'hA5);                     // ignored in error state
        send_ctrl(EV_ADDR_W);                 // ignored in error state
        send_ctrl(EV_STOP);
        send_data(8'h5A);                     // data while idle
        send_ctrl(EV_STOP);
        send_ctrl(EV_ADDR_W);
        send_event(EV_DATA, 8'hFF, 1'b0);     // buffer not full
        send_ctrl(EV_STOP);
        send_packet(8'h00, 8'h00, 1'b1);
        send_ctrl(EV_ADDR_R);
        send_data(8'h00);                     // data after the packet is done
        send_ctrl(EV_STOP);
        send_packet(8'hFF, 8'hFF, 1'b1);
        send_ctrl(EV_ADDR_R);
        send_ctrl(EV_ADDR_R);
        send_packet(8'h12, 8'h34, 1'b0);      // address write restarts from done
        send_ctrl(EV_ADDR_R);
        send_ctrl(EV_STOP);

        // Random: mostly whole transactions, some broken ones, some noise
        while (sent_count < RANDOM_EVENTS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                send_packet(8'($urandom), 8'($urandom), $urandom_range(0, 2) != 0);
                repeat ($urandom_range(0, 2)) send_ctrl(EV_ADDR_R);
                if ($urandom_range(0, 4) != 0)
                    send_ctrl(EV_STOP);
            end
            else if (roll < 85)
            begin
                send_ctrl(EV_ADDR_W);
                k = $urandom_range(0, 2);
                repeat (k) send_data(8'($urandom));
                send_event(ev_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 1) != 0)
                    send_ctrl(EV_STOP);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_event(ev_t'($urandom_range(0, 3)), 8'($urandom),
                               $urandom_range(0, 3) != 0);
            end
        end
        in_valid <= 1'b0;

        // Let the checker count the last request before draining
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
